>>> design/sfcs_pkg.sv
// Shared types, constants and codes of the SPI flash command sequencer.
package sfcs_pkg;

    // Flash geometry.
    localparam int PAGE_BITS    = 8;
    localparam int PAGE_BYTES   = 1 << PAGE_BITS;
    localparam int SECTOR_BYTES = 65536;
    localparam int ADDRESS_BITS = 24;

    // Field widths.
    localparam int SECTORS_W = 9;
    localparam int POS_W     = 25;
    localparam int ADDR_W    = 24;
    localparam int CHUNK_W   = PAGE_BITS + 1;
    localparam int SIZE_W    = ADDRESS_BITS + 1;

    // Command bytes and status bits.
    localparam logic [7:0] OPC_PROGRAM = 8'h02;
    localparam logic [7:0] OPC_READ    = 8'h03;
    localparam logic [7:0] OPC_STATUS  = 8'h05;
    localparam logic [7:0] OPC_ERASE   = 8'hc7;
    localparam int         WIP_BIT     = 0;

    // Timeout register reset values in milliseconds.
    localparam logic [31:0] PROGRAM_TIMEOUT_RESET = 32'd500;
    localparam logic [31:0] ERASE_TIMEOUT_RESET   = 32'd300000;

    // Result queue depth.
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Input event kinds.
    typedef enum logic [2:0] {
        OP_READ_REQ    = 3'd0,
        OP_PROGRAM_REQ = 3'd1,
        OP_ERASE_REQ   = 3'd2,
        OP_XFER_DONE   = 3'd3,
        OP_STATUS_BYTE = 3'd4,
        OP_MS_TICK     = 3'd5,
        OP_XFER_FAIL   = 3'd6
    } op_e;

    // Result kinds.
    typedef enum logic [1:0] {
        ACT_ISSUE = 2'd0,
        ACT_OK    = 2'd1,
        ACT_FAIL  = 2'd2
    } action_e;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_DEVICE   = 3'd1,
        ERR_SIZE        = 3'd2,
        ERR_BAD_OFFSET  = 3'd3,
        ERR_TIMEOUT     = 3'd4,
        ERR_XFER_FAILED = 3'd5,
        ERR_BUSY        = 3'd6
    } err_e;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEVICE_PRESENT = 2'd0,
        CFG_CHIP_SIZE      = 2'd1,
        CFG_PROGRAM_TMO    = 2'd2,
        CFG_ERASE_TMO      = 2'd3
    } cfg_index_e;

    // Configuration register file.
    typedef struct packed {
        logic                 device_present;
        logic [SECTORS_W-1:0] chip_size_sectors;
        logic [31:0]          program_timeout_ms;
        logic [31:0]          erase_timeout_ms;
    } sfcs_cfg_t;

    // One result item.
    typedef struct packed {
        action_e              action;
        logic [7:0]           opcode;
        logic                 write_enable_first;
        logic [ADDR_W-1:0]    flash_address;
        logic [CHUNK_W-1:0]   chunk_length;
        logic [POS_W-1:0]     buffer_position;
        err_e                 error_code;
    } sfcs_result_t;

endpackage

>>> design/sfcs_core.sv
// Sequencer state and the combinational step logic for one registered item.
module sfcs_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  logic [2:0]           item_op,
    input  logic [31:0]          item_offset,
    input  logic [31:0]          item_length,
    input  logic [7:0]           item_status,
    input  sfcs_pkg::sfcs_cfg_t  cfg,
    output logic                 res_valid,
    output sfcs_pkg::sfcs_result_t res
);
    import sfcs_pkg::*;

    localparam int SECT_W = $clog2(SECTOR_BYTES + 1);
    localparam int PROD_W = (SECTORS_W + SECT_W > SIZE_W) ? SECTORS_W + SECT_W : SIZE_W;
    localparam logic [PROD_W-1:0] CHIP_CAP  = PROD_W'(1) << ADDRESS_BITS;
    localparam logic [POS_W-1:0]  ADDR_MASK = (POS_W'(1) << ADDRESS_BITS) - POS_W'(1);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_READ_XFER  = 3'd1,
        PH_PROG_XFER  = 3'd2,
        PH_PROG_POLL  = 3'd3,
        PH_ERASE_XFER = 3'd4,
        PH_ERASE_POLL = 3'd5
    } phase_e;

    phase_e             phase_reg,   phase_next;
    logic [POS_W-1:0]   addr_reg,    addr_next;
    logic [POS_W-1:0]   remain_reg,  remain_next;
    logic [POS_W-1:0]   bufpos_reg,  bufpos_next;
    logic [CHUNK_W-1:0] chunk_reg,   chunk_next;
    logic [31:0]        elapsed_reg, elapsed_next;

    logic [PROD_W-1:0]  size_prod;
    logic [32:0]        chip_size;
    logic [32:0]        req_end;
    err_e               req_err;
    logic [POS_W-1:0]   adv_addr;
    logic [POS_W-1:0]   adv_remain;
    logic [POS_W-1:0]   adv_bufpos;

    // Bytes of the next chunk: limited by the remaining length, the page size and the page boundary.
    function automatic logic [CHUNK_W-1:0] chunk_of(input logic [POS_W-1:0] addr,
                                                    input logic [POS_W-1:0] remain);
        logic [CHUNK_W-1:0] room;
        logic [CHUNK_W-1:0] n;
        room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(addr[PAGE_BITS-1:0]);
        n    = (remain < POS_W'(PAGE_BYTES)) ? remain[CHUNK_W-1:0] : CHUNK_W'(PAGE_BYTES);
        return (n < room) ? n : room;
    endfunction

    // Result item for an SPI transfer.
    function automatic sfcs_result_t issue(input logic [7:0] opcode, input logic we,
                                           input logic [POS_W-1:0] addr,
                                           input logic [CHUNK_W-1:0] len,
                                           input logic [POS_W-1:0] bufpos);
        sfcs_result_t r;
        r.action             = ACT_ISSUE;
        r.opcode             = opcode;
        r.write_enable_first = we;
        r.flash_address      = ADDR_W'(addr & ADDR_MASK);
        r.chunk_length       = len;
        r.buffer_position    = bufpos;
        r.error_code         = ERR_NONE;
        return r;
    endfunction

    // Result item that ends an operation.
    function automatic sfcs_result_t done(input err_e err);
        sfcs_result_t r;
        r            = '0;
        r.action     = (err == ERR_NONE) ? ACT_OK : ACT_FAIL;
        r.error_code = err;
        return r;
    endfunction

    // Chip size in bytes, capped at the address space.
    assign size_prod = PROD_W'(cfg.chip_size_sectors) * PROD_W'(SECTOR_BYTES);
    assign chip_size = (size_prod > CHIP_CAP) ? 33'(CHIP_CAP) : 33'(size_prod);
    assign req_end   = {1'b0, item_offset} + {1'b0, item_length};

    // Request check.
    always_comb begin
        if (!cfg.device_present) begin
            req_err = ERR_NO_DEVICE;
        end else if (cfg.chip_size_sectors == '0) begin
            req_err = ERR_SIZE;
        end else if ({1'b0, item_offset} >= chip_size || {1'b0, item_length} > chip_size
                     || req_end > chip_size) begin
            req_err = ERR_BAD_OFFSET;
        end else begin
            req_err = ERR_NONE;
        end
    end

    // Position after the chunk in flight completes.
    assign adv_addr   = addr_reg + POS_W'(chunk_reg);
    assign adv_remain = remain_reg - POS_W'(chunk_reg);
    assign adv_bufpos = bufpos_reg + POS_W'(chunk_reg);

    // Step logic for the current item.
    always_comb begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        remain_next  = remain_reg;
        bufpos_next  = bufpos_reg;
        chunk_next   = chunk_reg;
        elapsed_next = elapsed_reg;
        res_valid    = 1'b0;
        res          = '0;
        case (op_e'(item_op))
            OP_READ_REQ, OP_PROGRAM_REQ: begin
                res_valid = 1'b1;
                if (phase_reg != PH_IDLE) begin
                    res = done(ERR_BUSY);
                end else if (req_err != ERR_NONE) begin
                    res = done(req_err);
                end else if (item_length == '0) begin
                    res = done(ERR_NONE);
                end else begin
                    addr_next   = item_offset[POS_W-1:0];
                    remain_next = item_length[POS_W-1:0];
                    bufpos_next = '0;
                    chunk_next  = chunk_of(item_offset[POS_W-1:0], item_length[POS_W-1:0]);
                    if (op_e'(item_op) == OP_READ_REQ) begin
                        phase_next = PH_READ_XFER;
                        res = issue(OPC_READ, 1'b0, item_offset[POS_W-1:0], chunk_next, '0);
                    end else begin
                        phase_next = PH_PROG_XFER;
                        res = issue(OPC_PROGRAM, 1'b1, item_offset[POS_W-1:0], chunk_next,
                                    '0);
                    end
                end
            end
            OP_ERASE_REQ: begin
                res_valid = 1'b1;
                if (phase_reg != PH_IDLE) begin
                    res = done(ERR_BUSY);
                end else if (!cfg.device_present) begin
                    res = done(ERR_NO_DEVICE);
                end else begin
                    phase_next = PH_ERASE_XFER;
                    res = issue(OPC_ERASE, 1'b1, '0, '0, '0);
                end
            end
            OP_XFER_DONE: begin
                if (phase_reg == PH_READ_XFER) begin
                    res_valid   = 1'b1;
                    addr_next   = adv_addr;
                    remain_next = adv_remain;
                    bufpos_next = adv_bufpos;
                    chunk_next  = chunk_of(adv_addr, adv_remain);
                    if (adv_remain == '0) begin
                        phase_next = PH_IDLE;
                        res = done(ERR_NONE);
                    end else begin
                        res = issue(OPC_READ, 1'b0, adv_addr, chunk_next, adv_bufpos);
                    end
                end else if (phase_reg == PH_PROG_XFER || phase_reg == PH_ERASE_XFER) begin
                    res_valid    = 1'b1;
                    phase_next   = (phase_reg == PH_PROG_XFER) ? PH_PROG_POLL : PH_ERASE_POLL;
                    elapsed_next = '0;
                    res = issue(OPC_STATUS, 1'b0, '0, CHUNK_W'(1), '0);
                end
            end
            OP_STATUS_BYTE: begin
                if (phase_reg == PH_PROG_POLL || phase_reg == PH_ERASE_POLL) begin
                    res_valid = 1'b1;
                    if (!item_status[WIP_BIT]) begin
                        if (phase_reg == PH_ERASE_POLL) begin
                            phase_next = PH_IDLE;
                            res = done(ERR_NONE);
                        end else begin
                            addr_next   = adv_addr;
                            remain_next = adv_remain;
                            bufpos_next = adv_bufpos;
                            chunk_next  = chunk_of(adv_addr, adv_remain);
                            if (adv_remain == '0) begin
                                phase_next = PH_IDLE;
                                res = done(ERR_NONE);
                            end else begin
                                phase_next = PH_PROG_XFER;
                                res = issue(OPC_PROGRAM, 1'b1, adv_addr, chunk_next,
                                            adv_bufpos);
                            end
                        end
                    end else if (elapsed_reg > ((phase_reg == PH_PROG_POLL) ?
                                 cfg.program_timeout_ms : cfg.erase_timeout_ms)) begin
                        phase_next = PH_IDLE;
                        res = done(ERR_TIMEOUT);
                    end else begin
                        res = issue(OPC_STATUS, 1'b0, '0, CHUNK_W'(1), '0);
                    end
                end
            end
            OP_MS_TICK: begin
                if ((phase_reg == PH_PROG_POLL || phase_reg == PH_ERASE_POLL) &&
                    elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end
            OP_XFER_FAIL: begin
                if (phase_reg != PH_IDLE) begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                    res = done(ERR_XFER_FAILED);
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, advanced once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            addr_reg    <= '0;
            remain_reg  <= '0;
            bufpos_reg  <= '0;
            chunk_reg   <= '0;
            elapsed_reg <= '0;
        end else if (item_valid) begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            remain_reg  <= remain_next;
            bufpos_reg  <= bufpos_next;
            chunk_reg   <= chunk_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

>>> design/sfcs_result_fifo.sv
// Three-entry result queue that holds finished items until the sink takes them.
module sfcs_result_fifo (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  sfcs_pkg::sfcs_result_t               push_data,
    input  logic                                 pop,
    output logic                                 out_valid,
    output sfcs_pkg::sfcs_result_t               out_data,
    output logic [sfcs_pkg::FIFO_CNT_W-1:0]      count
);
    import sfcs_pkg::*;

    sfcs_result_t            mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg,  count_next;
    logic                    do_pop;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && out_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/spi_flash_command_sequencer.sv
// An input item is captured in the input register and stepped by the core, and its result item
// is written into the result queue, from which the sink takes it.
// Input is taken at one item per cycle while s_tready is high; the step logic is combinational.
// A three-entry result queue lets input continue while results wait for the sink; input
// stalls only while the queue and the input register together hold three items.
// Reset is synchronous on aresetn low: the sequencer goes idle, the queue empties,
// and the configuration registers return to their defaults.
module spi_flash_command_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // offset[31:0], length[63:32], status_byte[71:64]
    input  logic [2:0]  s_tuser,    // op[2:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // opcode[7:0], write_enable_first[8],
                                    // flash_address[32:9], chunk_length[41:33],
                                    // buffer_position[66:42], error_code[69:67], zeros
    output logic [1:0]  m_tuser,    // action[1:0]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sfcs_pkg::*;

    sfcs_cfg_t              cfg_reg, cfg_next;
    logic                   in_valid_reg;
    logic [2:0]             in_op_reg;
    logic [31:0]            in_offset_reg;
    logic [31:0]            in_length_reg;
    logic [7:0]             in_status_reg;
    logic                   s_accept;
    logic                   core_valid;
    sfcs_result_t           core_res;
    sfcs_result_t           out_res;
    logic [FIFO_CNT_W-1:0]  fifo_count;
    logic                   m_pop;

    // Input is taken only while the queue has room for every item in flight.
    assign s_tready  = ({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(in_valid_reg))
                       < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_pop     = m_tvalid && m_tready;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_e'(cfg_index))
                CFG_DEVICE_PRESENT: cfg_next.device_present     = cfg_data[0];
                CFG_CHIP_SIZE:      cfg_next.chip_size_sectors  = cfg_data[SECTORS_W-1:0];
                CFG_PROGRAM_TMO:    cfg_next.program_timeout_ms = cfg_data;
                CFG_ERASE_TMO:      cfg_next.erase_timeout_ms   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_present     <= 1'b0;
            cfg_reg.chip_size_sectors  <= '0;
            cfg_reg.program_timeout_ms <= PROGRAM_TIMEOUT_RESET;
            cfg_reg.erase_timeout_ms   <= ERASE_TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg     <= s_tuser;
            in_offset_reg <= s_tdata[31:0];
            in_length_reg <= s_tdata[63:32];
            in_status_reg <= s_tdata[71:64];
        end
    end

    sfcs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .item_op     (in_op_reg),
        .item_offset (in_offset_reg),
        .item_length (in_length_reg),
        .item_status (in_status_reg),
        .cfg         (cfg_reg),
        .res_valid   (core_valid),
        .res         (core_res)
    );

    sfcs_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_valid_reg && core_valid),
        .push_data (core_res),
        .pop       (m_pop),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    // Result packing, first field in the lowest bits.
    assign m_tuser = out_res.action;
    assign m_tdata = {2'b00, out_res.error_code, out_res.buffer_position,
                      out_res.chunk_length, out_res.flash_address,
                      out_res.write_enable_first, out_res.opcode};

`ifndef SYNTHESIS
    // A result is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && core_valid) |-> (fifo_count != FIFO_CNT_W'(FIFO_DEPTH) || m_pop))
        else $error("result pushed into a full queue");

    // A transfer item never carries an error code.
    a_issue_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.action == ACT_ISSUE) |-> (out_res.error_code == ERR_NONE))
        else $error("transfer item carries an error code");

    // A failed item always names its error.
    a_fail_coded: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.action == ACT_FAIL) |-> (out_res.error_code != ERR_NONE))
        else $error("failed item without an error code");
`endif

endmodule
